>>> rtl/fixed_block_pool_allocator_defines.svh
// Assertion macros shared by the fixed block pool allocator modules.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FBPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fbpa assertion failed");

// Next-cycle implication, checked outside reset.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fbpa assertion failed");

`endif

>>> rtl/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

	localparam int MAX_BLOCKS   = 1024;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int LINK_W       = IDX_W + 1;
	localparam int ADDR_W       = 32;
	localparam int REQ_W        = 16;
	localparam int CNT_W        = 11;
	localparam int STRIDE_ALIGN = 16;
	localparam int ALIGN_W      = $clog2(STRIDE_ALIGN);
	localparam int STRIDE_W     = REQ_W + 1;
	localparam int LAST_W       = IDX_W + STRIDE_W;
	localparam int STEP_W       = $clog2(IDX_W);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = QPTR_W + 1;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;
	localparam int STATUS_W     = 2;

	// Link value that terminates the free list.
	localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);

	// Register indexes (paddr[3:2]).
	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_SIZE  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_ALLOC,
		K_FREE,
		K_REJECT
	} job_kind_t;

	// One classified request travelling from the front to the back.
	typedef struct packed {
		job_kind_t        kind;
		logic             clr;
		logic [IDX_W-1:0] idx;
	} job_t;

	// Pool geometry derived from the configuration registers.
	typedef struct packed {
		logic [ADDR_W-1:0]   base;
		logic [STRIDE_W-1:0] stride;
		logic [LAST_W-1:0]   last;
		logic [CNT_W-1:0]    cnt;
		logic                cnt_zero;
	} geom_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_SWEEP,
		B_RUN,
		B_GRANT
	} back_state_t;

endpackage

>>> rtl/fbpa_front.sv
// Request front end: accepts requests, range-checks frees and finds the block index.
module fbpa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fbpa_pkg::geom_t             geom,
	input  logic                        hold,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        opcode,
	input  logic                        clear_on_alloc,
	input  logic [fbpa_pkg::ADDR_W-1:0] address,
	output logic                        push,
	output fbpa_pkg::job_t              push_job,
	input  logic                        full
);
	import fbpa_pkg::*;

	front_state_t      state_q, state_d;
	logic [LAST_W-1:0] rem_q, rem_d;
	logic [LAST_W-1:0] dvs_q, dvs_d;
	logic [IDX_W-1:0]  quo_q, quo_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [ADDR_W-1:0] offset;
	logic              in_range;
	logic              accept;
	logic              ge;

	assign offset   = address - geom.base;
	assign in_range = !geom.cnt_zero && (offset <= ADDR_W'(geom.last));
	assign req_stall = (state_q != F_IDLE) || full || hold;
	assign accept   = req_valid && !req_stall;
	assign ge       = (rem_q >= dvs_q);

	always_comb begin
		state_d  = state_q;
		rem_d    = rem_q;
		dvs_d    = dvs_q;
		quo_d    = quo_q;
		step_d   = step_q;
		push     = 1'b0;
		push_job = '{kind: K_REJECT, clr: 1'b0, idx: '0};
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (opcode == OP_ALLOC) begin
						push     = 1'b1;
						push_job = '{kind: K_ALLOC, clr: clear_on_alloc, idx: '0};
					end else if (in_range) begin
						rem_d   = offset[LAST_W-1:0];
						dvs_d   = LAST_W'(geom.stride) << (IDX_W - 1);
						quo_d   = '0;
						step_d  = STEP_W'(IDX_W - 1);
						state_d = F_DIV;
					end else begin
						push = 1'b1;
					end
				end
			end
			F_DIV: begin
				// Restoring division, one quotient bit per cycle.
				rem_d  = ge ? (rem_q - dvs_q) : rem_q;
				quo_d  = {quo_q[IDX_W-2:0], ge};
				dvs_d  = dvs_q >> 1;
				step_d = step_q - STEP_W'(1);
				if (step_q == '0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!full) begin
					push = 1'b1;
					// A nonzero remainder means the address is not on a block start.
					push_job = '{kind: (rem_q == '0) ? K_FREE : K_REJECT, clr: 1'b0,
						idx: quo_q};
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		dvs_q  <= dvs_d;
		quo_q  <= quo_d;
		step_q <= step_d;
	end

endmodule

>>> rtl/fbpa_queue.sv
// Short request queue between the front end and the free-list engine.
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fbpa_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output fbpa_pkg::job_t head_job,
	output logic           nonempty
);
	import fbpa_pkg::*;

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	`FBPA_ASSERT_IMP(a_no_push_when_full, clk, arst_n, push, !full)
	`FBPA_ASSERT_IMP(a_no_pop_when_empty, clk, arst_n, pop, nonempty)

endmodule

>>> rtl/fbpa_back.sv
// Free-list engine: link memory, list head, free count and the result register.
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbpa_pkg::geom_t               geom,
	input  logic                          rebuild,
	output logic                          sweeping,
	input  logic                          job_valid,
	input  fbpa_pkg::job_t                job,
	output logic                          job_pop,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [fbpa_pkg::STATUS_W-1:0] status,
	output logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	output logic                          clear_request,
	output logic [fbpa_pkg::CNT_W-1:0]    free_count,
	output logic                          pool_empty,
	output logic [fbpa_pkg::STRIDE_W-1:0] chunk_stride
);
	import fbpa_pkg::*;

	logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
	logic [LINK_W-1:0] rdata_q;

	back_state_t       state_q, state_d;
	logic [LINK_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  total_q, total_d;
	logic [IDX_W-1:0]  sweep_q, sweep_d;
	logic              out_valid_q;
	logic              grant_clr_q, grant_clr_d;
	logic [LAST_W-1:0] prod_q;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [LINK_W-1:0] mem_wd;
	logic              mem_re;
	logic              prod_load;
	logic [LINK_W-1:0] chain_next;
	logic              out_free;
	logic              out_load;
	status_t           out_status_d;
	logic [ADDR_W-1:0] out_addr_d;
	logic              out_clr_d;

	status_t             status_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                clr_q;
	logic [CNT_W-1:0]    count_q;
	logic                empty_q;
	logic [STRIDE_W-1:0] stride_q;

	assign sweeping   = (state_q == B_SWEEP);
	assign out_free   = !out_valid_q || !rsp_stall;
	assign chain_next = LINK_W'(sweep_q) + LINK_W'(1);

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		total_d      = total_q;
		sweep_d      = sweep_q;
		grant_clr_d  = grant_clr_q;
		mem_we       = 1'b0;
		mem_wa       = job.idx;
		mem_wd       = head_q;
		mem_re       = 1'b0;
		prod_load    = 1'b0;
		job_pop      = 1'b0;
		out_load     = 1'b0;
		out_status_d = ST_DONE;
		out_addr_d   = '0;
		out_clr_d    = 1'b0;
		unique case (state_q)
			B_SWEEP: begin
				// Lay down the initial chain, one link per cycle.
				mem_we = 1'b1;
				mem_wa = sweep_q;
				mem_wd = (CNT_W'(chain_next) < geom.cnt) ? chain_next : END_MARK;
				sweep_d = sweep_q + IDX_W'(1);
				if (sweep_q == IDX_W'(MAX_BLOCKS - 1)) begin
					state_d = B_RUN;
				end
			end
			B_RUN: begin
				if (job_valid && out_free) begin
					job_pop = 1'b1;
					case (job.kind)
						K_ALLOC: begin
							if (head_q == END_MARK) begin
								out_load     = 1'b1;
								out_status_d = ST_EMPTY;
							end else begin
								mem_re      = 1'b1;
								prod_load   = 1'b1;
								grant_clr_d = job.clr;
								state_d     = B_GRANT;
							end
						end
						K_FREE: begin
							mem_we   = 1'b1;
							mem_wa   = job.idx;
							mem_wd   = head_q;
							head_d   = LINK_W'(job.idx);
							if (total_q < CNT_W'(MAX_BLOCKS)) begin
								total_d = total_q + CNT_W'(1);
							end
							out_load = 1'b1;
						end
						default: begin
							out_load     = 1'b1;
							out_status_d = ST_REJECT;
						end
					endcase
				end
			end
			B_GRANT: begin
				// The popped block's link is back from memory.
				head_d = rdata_q;
				if (total_q != '0) begin
					total_d = total_q - CNT_W'(1);
				end
				out_load   = 1'b1;
				out_addr_d = geom.base + ADDR_W'(prod_q);
				out_clr_d  = grant_clr_q;
				state_d    = B_RUN;
			end
			default: state_d = B_SWEEP;
		endcase
		if (rebuild) begin
			state_d = B_SWEEP;
			sweep_d = '0;
			head_d  = geom.cnt_zero ? END_MARK : '0;
			total_d = geom.cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_SWEEP;
			head_q      <= '0;
			total_q     <= CNT_W'(MAX_BLOCKS);
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			total_q <= total_d;
			sweep_q <= sweep_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= link_mem[head_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		grant_clr_q <= grant_clr_d;
		if (prod_load) begin
			prod_q <= {{(LAST_W-IDX_W){1'b0}}, head_q[IDX_W-1:0]} *
				{{(LAST_W-STRIDE_W){1'b0}}, geom.stride};
		end
		if (out_load) begin
			status_q <= out_status_d;
			addr_q   <= out_addr_d;
			clr_q    <= out_clr_d;
			count_q  <= total_d;
			empty_q  <= (head_d == END_MARK);
			stride_q <= geom.stride;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign status        = status_q;
	assign block_address = addr_q;
	assign clear_request = clr_q;
	assign free_count    = count_q;
	assign pool_empty    = empty_q;
	assign chunk_stride  = stride_q;

	`FBPA_ASSERT_IMP(a_total_bounded, clk, arst_n, 1'b1, total_q <= CNT_W'(MAX_BLOCKS))
	`FBPA_ASSERT_IMP(a_empty_list_no_count, clk, arst_n,
		(state_q != B_SWEEP) && (head_q == END_MARK), total_q == '0)
	`FBPA_ASSERT_IMP(a_grant_slot_free, clk, arst_n, state_q == B_GRANT, !out_valid_q)
	`FBPA_ASSERT_NEXT(a_rebuild_sweeps, clk, arst_n, rebuild, state_q == B_SWEEP)

endmodule

>>> rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: register port, front end, queue, engine.
//
// Requests enter on the req channel (req_valid, req_stall, opcode, clear_on_alloc,
// address) and one result per request leaves on the rsp channel (rsp_valid,
// rsp_stall, status, block_address, clear_request, free_count, pool_empty,
// chunk_stride). A transfer happens on a rising edge with valid high and stall low.
// The front end classifies each request: an allocate goes straight to the queue,
// a free is range-checked against the pool and its block index found by a
// restoring divider that produces one quotient bit per cycle. The engine behind
// the two-entry queue owns the link memory; an allocate costs one memory read
// and the B_GRANT state to pick up the new head, so the engine takes no new job
// while it finishes an allocate; rsp_valid rises once B_GRANT loads the result.
// A free in range occupies the front end through its entry, ten divider steps
// and the hand-off in F_PUSH; a free outside the pool is pushed straight from
// the idle state. After reset, and after every write to a configuration
// register, the engine rebuilds the free list by sweeping all 1024 links, one
// per cycle. req_stall stays high throughout the sweep, and after a write also
// while rebuild_q starts it. While rsp_stall is high the result register keeps
// its request; the queue and the front end keep accepting until they are full.
module fixed_block_pool_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
	input  logic [fbpa_pkg::PDATA_W-1:0]  pwdata,
	output logic [fbpa_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// Request channel.
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          opcode,
	input  logic                          clear_on_alloc,
	input  logic [fbpa_pkg::ADDR_W-1:0]   address,
	// Result channel.
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [fbpa_pkg::STATUS_W-1:0] status,
	output logic [fbpa_pkg::ADDR_W-1:0]   block_address,
	output logic                          clear_request,
	output logic [fbpa_pkg::CNT_W-1:0]    free_count,
	output logic                          pool_empty,
	output logic [fbpa_pkg::STRIDE_W-1:0] chunk_stride
);
	import fbpa_pkg::*;

	logic [ADDR_W-1:0]   base_q;
	logic [REQ_W-1:0]    size_q;
	logic [CNT_W-1:0]    count_q;
	logic [LAST_W-1:0]   last_q;
	logic                rebuild_q;

	logic                cfg_write;
	logic                cfg_hit;
	logic [1:0]          reg_idx;
	logic [STRIDE_W-1:0] stride;
	logic [CNT_W-1:0]    cnt_sat;
	logic [IDX_W-1:0]    cnt_m1;
	geom_t               geom;

	logic                push;
	job_t                push_job;
	logic                full;
	logic                job_pop;
	job_t                head_job;
	logic                nonempty;
	logic                sweeping;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_hit   = (reg_idx == REG_BASE) || (reg_idx == REG_SIZE) ||
		(reg_idx == REG_COUNT);

	// Round the request up to the next multiple of the alignment; an exact
	// multiple still gains one full alignment step.
	assign stride  = STRIDE_W'({size_q[REQ_W-1:ALIGN_W], {ALIGN_W{1'b0}}}) +
		STRIDE_W'(STRIDE_ALIGN);
	assign cnt_sat = (count_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_q;
	assign cnt_m1  = IDX_W'(cnt_sat - CNT_W'(1));

	assign geom.base     = base_q;
	assign geom.stride   = stride;
	assign geom.last     = last_q;
	assign geom.cnt      = cnt_sat;
	assign geom.cnt_zero = (count_q == '0);

	always_comb begin
		unique case (reg_idx)
			REG_BASE:  prdata = PDATA_W'(base_q);
			REG_SIZE:  prdata = PDATA_W'(size_q);
			REG_COUNT: prdata = PDATA_W'(count_q);
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			size_q    <= REQ_W'(32);
			count_q   <= CNT_W'(MAX_BLOCKS);
			rebuild_q <= 1'b0;
		end else begin
			// The rebuild request is registered, so it starts in the cycle after the write
			// and the engine sees the new register values.
			rebuild_q <= cfg_write && cfg_hit;
			if (cfg_write) begin
				case (reg_idx)
					REG_BASE:  base_q  <= pwdata[ADDR_W-1:0];
					REG_SIZE:  size_q  <= pwdata[REQ_W-1:0];
					REG_COUNT: count_q <= pwdata[CNT_W-1:0];
					default:   ;
				endcase
			end
		end
	end

	// Offset of the last block start; settles well inside the rebuild sweep.
	always_ff @(posedge clk) begin
		last_q <= {{(LAST_W-IDX_W){1'b0}}, cnt_m1} * {{(LAST_W-STRIDE_W){1'b0}}, stride};
	end

	fbpa_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.geom           (geom),
		.hold           (sweeping || rebuild_q),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.opcode         (opcode),
		.clear_on_alloc (clear_on_alloc),
		.address        (address),
		.push           (push),
		.push_job       (push_job),
		.full           (full)
	);

	fbpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (job_pop),
		.head_job (head_job),
		.nonempty (nonempty)
	);

	fbpa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.geom          (geom),
		.rebuild       (rebuild_q),
		.sweeping      (sweeping),
		.job_valid     (nonempty),
		.job           (head_job),
		.job_pop       (job_pop),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.block_address (block_address),
		.clear_request (clear_request),
		.free_count    (free_count),
		.pool_empty    (pool_empty),
		.chunk_stride  (chunk_stride)
	);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the fixed block pool allocator.
`timescale 1ns / 1ps

module tb;
	import fbpa_pkg::*;

	// Cycles without any request, result or register write before the run is
	// declared hung. The slowest quiet stretch is one rebuild sweep after a
	// register write, longer than the long result hold-off and the longest sender
	// gap, so this is many times the worst case.
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int PRESSURE_CYCLES = 300;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PRESSURE_PHASE  = 1;
	localparam int DRAIN_CYCLES    = 20;
	localparam int SWEEP_SETTLE    = 3;

	// One row of the directed plan: either a register write or a request.
	typedef enum logic {
		ROW_WRITE,
		ROW_REQUEST
	} plan_kind_t;

	// Everything the block reports for one request.
	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   blk;
		logic                clr;
		logic [CNT_W-1:0]    free_cnt;
		logic                empty;
		logic [STRIDE_W-1:0] stride;
	} pool_result_t;

	typedef struct {
		plan_kind_t        kind;
		logic [1:0]        reg_idx;
		opcode_t           op;
		logic              clr;
		logic [ADDR_W-1:0] value;
		bit                typed;
		pool_result_t      want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                req_valid;
	logic                req_stall;
	logic                opcode;
	logic                clear_on_alloc;
	logic [ADDR_W-1:0]   address;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   block_address;
	logic                clear_request;
	logic [CNT_W-1:0]    free_count;
	logic                pool_empty;
	logic [STRIDE_W-1:0] chunk_stride;

	// Shadow of the pool: configuration plus the free list itself.
	logic [ADDR_W-1:0]   pool_base;
	logic [REQ_W-1:0]    pool_size;
	logic [CNT_W-1:0]    pool_count_reg;
	logic [CNT_W-1:0]    pool_blocks;
	logic [STRIDE_W-1:0] pool_stride;
	logic [LINK_W-1:0]   next_free [MAX_BLOCKS];
	logic [LINK_W-1:0]   free_top;
	logic [CNT_W-1:0]    blocks_free;

	// Results still owed by the block, oldest first, and the blocks that the
	// stimulus currently holds and may hand back.
	pool_result_t        expected_results [$];
	logic [ADDR_W-1:0]   granted_blocks [$];
	plan_row_t           directed_plan [$];

	int                  fail_count = 0;
	int                  idle_cycles = 0;
	bit                  burst_mode = 1'b0;
	bit                  hold_rsp = 1'b0;
	bit                  hold_done = 1'b0;

	fixed_block_pool_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.clear_on_alloc(clear_on_alloc),
		.address(address),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.block_address(block_address),
		.clear_request(clear_request),
		.free_count(free_count),
		.pool_empty(pool_empty),
		.chunk_stride(chunk_stride)
	);

	always #5 clk = ~clk;

	// Rebuild the shadow free list as the chain 0, 1, ..., count-1. The block
	// does the same after reset and after every register write.
	function automatic void rebuild_pool();
		int i;
		pool_blocks = (pool_count_reg > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : pool_count_reg;
		// An exact multiple of the alignment still grows by one alignment step.
		pool_stride = STRIDE_W'(pool_size) + STRIDE_W'(STRIDE_ALIGN)
			- STRIDE_W'(pool_size % STRIDE_ALIGN);
		for (i = 0; i < MAX_BLOCKS; i++) begin
			next_free[i] = (i + 1 < pool_blocks) ? LINK_W'(i + 1) : END_MARK;
		end
		free_top = (pool_blocks != 0) ? '0 : END_MARK;
		blocks_free = pool_blocks;
		granted_blocks.delete();
	endfunction

	// Work out what the block answers to one request and update the shadow
	// free list the same way.
	function automatic pool_result_t predict_pool(opcode_t op, logic clr,
			logic [ADDR_W-1:0] addr);
		pool_result_t res;
		logic [ADDR_W-1:0] off;
		logic [IDX_W-1:0] slot;
		res = '0;
		res.status = ST_DONE;
		res.stride = pool_stride;
		if (op == OP_ALLOC) begin
			if (free_top >= END_MARK) begin
				res.status = ST_EMPTY;
			end else begin
				slot = free_top[IDX_W-1:0];
				// Granted addresses wrap around the top of the address space.
				res.blk = ADDR_W'(64'(pool_base) + 64'(slot) * 64'(pool_stride));
				free_top = next_free[slot];
				if (blocks_free != 0) blocks_free = blocks_free - CNT_W'(1);
				res.clr = clr;
			end
		end else begin
			// The offset is taken modulo the address space, so an address
			// below the base lands far beyond the last block and is rejected.
			off = addr - pool_base;
			if (pool_blocks != 0 &&
					64'(off) <= 64'(pool_blocks - CNT_W'(1)) * 64'(pool_stride) &&
					64'(off) % 64'(pool_stride) == 0) begin
				// A double free is accepted and pushed again.
				slot = IDX_W'(64'(off) / 64'(pool_stride));
				next_free[slot] = free_top;
				free_top = LINK_W'(slot);
				if (blocks_free < MAX_BLOCKS) blocks_free = blocks_free + CNT_W'(1);
			end else begin
				res.status = ST_REJECT;
			end
		end
		res.free_cnt = blocks_free;
		res.empty = (free_top >= END_MARK);
		return res;
	endfunction

	function automatic pool_result_t outcome(status_t st, logic [ADDR_W-1:0] blk, logic clr,
			logic [CNT_W-1:0] cnt, logic empty, logic [STRIDE_W-1:0] stride);
		pool_result_t res;
		res.status = st;
		res.blk = blk;
		res.clr = clr;
		res.free_cnt = cnt;
		res.empty = empty;
		res.stride = stride;
		return res;
	endfunction

	function automatic plan_row_t write_row(logic [1:0] idx, logic [ADDR_W-1:0] value);
		plan_row_t row;
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.op = OP_ALLOC;
		row.clr = 1'b0;
		row.value = value;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic plan_row_t request_row(opcode_t op, logic clr, logic [ADDR_W-1:0] addr);
		plan_row_t row;
		row = write_row(REG_BASE, addr);
		row.kind = ROW_REQUEST;
		row.op = op;
		row.clr = clr;
		return row;
	endfunction

	function automatic plan_row_t checked_row(opcode_t op, logic clr, logic [ADDR_W-1:0] addr,
			pool_result_t want);
		plan_row_t row;
		row = request_row(op, clr, addr);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	// Sender gaps: mostly none, sometimes a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 50);
	endfunction

	function automatic logic [PDATA_W-1:0] pick_base();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [PDATA_W-1:0] pick_size();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'd65535;
			2: return 32'($urandom_range(1, 64) * STRIDE_ALIGN);
			3: return 32'($urandom_range(1, 300));
			default: return 32'($urandom_range(1, 65535));
		endcase
	endfunction

	// Small pools dominate so that the list runs dry and refills often.
	function automatic logic [PDATA_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd1024;
			3: return 32'd2047;
			4: return 32'($urandom_range(17, 200));
			default: return 32'($urandom_range(2, 16));
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// All stimulus tasks are entered just after a falling edge and return
	// just after one, so every input changes only at falling edges.

	// Offer one request, hold it until the block takes it, then predict it.
	task automatic issue_request(opcode_t op, logic clr, logic [ADDR_W-1:0] addr, bit typed,
			pool_result_t want);
		int gap;
		pool_result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		clear_on_alloc <= clr;
		address <= addr;
		do @(posedge clk); while (req_stall);
		predicted = predict_pool(op, clr, addr);
		if (op == OP_ALLOC && predicted.status == ST_DONE) granted_blocks.push_back(predicted.blk);
		expected_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Stop offering requests and wait until every owed result has come back.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One register write: setup cycle, access cycle, then let the rebuild
	// sweep that the write starts run to its end.
	task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BASE:  pool_base = value;
			REG_SIZE:  pool_size = value[REQ_W-1:0];
			REG_COUNT: pool_count_reg = value[CNT_W-1:0];
			default: ;
		endcase
		rebuild_pool();
		repeat (SWEEP_SETTLE) @(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Result side: random stall stretches, plus one long hold-off while the
	// sender keeps pushing so that the queue and front end fill and the
	// block has to stall its request channel.
	initial begin : result_side
		int run_left;
		int r;
		rsp_stall = 1'b0;
		run_left = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp && !hold_done) begin
				rsp_stall <= 1'b1;
				repeat (PRESSURE_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					rsp_stall <= 1'b0;
					run_left = $urandom_range(0, 20);
				end else if (r < 93) begin
					rsp_stall <= 1'b1;
					run_left = $urandom_range(0, 3);
				end else begin
					rsp_stall <= 1'b1;
					run_left = $urandom_range(10, 60);
				end
			end
		end
	end

	// Every accepted result must match the oldest owed result field by field.
	always @(posedge clk) begin : result_check
		pool_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending", block_address, '0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", ADDR_W'(status), ADDR_W'(want.status));
				if (block_address !== want.blk)
					report_mismatch("block_address", block_address, want.blk);
				if (clear_request !== want.clr)
					report_mismatch("clear_request", ADDR_W'(clear_request), ADDR_W'(want.clr));
				if (free_count !== want.free_cnt)
					report_mismatch("free_count", ADDR_W'(free_count), ADDR_W'(want.free_cnt));
				if (pool_empty !== want.empty)
					report_mismatch("pool_empty", ADDR_W'(pool_empty), ADDR_W'(want.empty));
				if (chunk_stride !== want.stride)
					report_mismatch("chunk_stride", ADDR_W'(chunk_stride), ADDR_W'(want.stride));
			end
		end
	end

	// Hang detector: any request, result or register write restarts the count.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(psel && penable && pwrite)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fixed_block_pool_allocator verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int row;
		int phase;
		int n;
		int r;
		int k;
		opcode_t op;
		logic clr;
		logic [ADDR_W-1:0] addr;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		opcode = OP_ALLOC;
		clear_on_alloc = 1'b0;
		address = '0;

		pool_base = '0;
		pool_size = REQ_W'(32);
		pool_count_reg = CNT_W'(1024);
		rebuild_pool();

		// Reset defaults: base 0, request 32 bytes (stride 48), 1024 blocks.
		directed_plan.push_back(checked_row(OP_ALLOC, 1'b1, 32'h0,
			outcome(ST_DONE, 32'h0, 1'b1, 11'd1023, 1'b0, 17'd48)));
		directed_plan.push_back(checked_row(OP_ALLOC, 1'b0, 32'hffff_ffff,
			outcome(ST_DONE, 32'd48, 1'b0, 11'd1022, 1'b0, 17'd48)));
		directed_plan.push_back(checked_row(OP_FREE, 1'b0, 32'd48,
			outcome(ST_DONE, 32'h0, 1'b0, 11'd1023, 1'b0, 17'd48)));
		// Misaligned free.
		directed_plan.push_back(checked_row(OP_FREE, 1'b0, 32'd47,
			outcome(ST_REJECT, 32'h0, 1'b0, 11'd1023, 1'b0, 17'd48)));
		// Last block, which is still free, so this is a double free.
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'd49104));
		// One stride past the last block, then the top address with the
		// zeroing flag set on a free, which the block ignores.
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'd49152));
		directed_plan.push_back(request_row(OP_FREE, 1'b1, 32'hffff_ffff));
		directed_plan.push_back(request_row(OP_ALLOC, 1'b0, 32'h0));

		// One block just below the top of the address space, exact multiple
		// request size so the stride grows to 32.
		directed_plan.push_back(write_row(REG_COUNT, 32'd1));
		directed_plan.push_back(write_row(REG_BASE, 32'hffff_fff0));
		directed_plan.push_back(write_row(REG_SIZE, 32'd16));
		directed_plan.push_back(checked_row(OP_ALLOC, 1'b1, 32'h0,
			outcome(ST_DONE, 32'hffff_fff0, 1'b1, 11'd0, 1'b1, 17'd32)));
		directed_plan.push_back(checked_row(OP_ALLOC, 1'b1, 32'h0,
			outcome(ST_EMPTY, 32'h0, 1'b0, 11'd0, 1'b1, 17'd32)));
		directed_plan.push_back(checked_row(OP_FREE, 1'b0, 32'hffff_fff0,
			outcome(ST_DONE, 32'h0, 1'b0, 11'd1, 1'b0, 17'd32)));
		// Offset wraps past the top and lands beyond the single block.
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'h0000_0010));

		// Empty pool: nothing to grant and nothing can be freed.
		directed_plan.push_back(write_row(REG_COUNT, 32'd0));
		directed_plan.push_back(checked_row(OP_ALLOC, 1'b1, 32'h0,
			outcome(ST_EMPTY, 32'h0, 1'b0, 11'd0, 1'b1, 17'd32)));
		directed_plan.push_back(checked_row(OP_FREE, 1'b0, 32'hffff_fff0,
			outcome(ST_REJECT, 32'h0, 1'b0, 11'd0, 1'b1, 17'd32)));

		// Count above capacity saturates; largest request gives a 64 KiB stride.
		directed_plan.push_back(write_row(REG_COUNT, 32'd2047));
		directed_plan.push_back(write_row(REG_SIZE, 32'd65535));
		directed_plan.push_back(write_row(REG_BASE, 32'h8000_0000));
		directed_plan.push_back(checked_row(OP_ALLOC, 1'b0, 32'h0,
			outcome(ST_DONE, 32'h8000_0000, 1'b0, 11'd1023, 1'b0, 17'd65536)));
		directed_plan.push_back(request_row(OP_ALLOC, 1'b1, 32'h0));
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'h83ff_0000));
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'h8400_0000));
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'h7fff_ffff));

		// Request size zero gives the minimum stride; two blocks straddling
		// the top of the address space.
		directed_plan.push_back(write_row(REG_SIZE, 32'd0));
		directed_plan.push_back(write_row(REG_COUNT, 32'd2));
		directed_plan.push_back(write_row(REG_BASE, 32'hffff_ffff));
		directed_plan.push_back(request_row(OP_ALLOC, 1'b1, 32'h0));
		directed_plan.push_back(request_row(OP_ALLOC, 1'b0, 32'h0));
		directed_plan.push_back(request_row(OP_ALLOC, 1'b1, 32'h0));
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'h0000_000f));
		directed_plan.push_back(request_row(OP_FREE, 1'b0, 32'h0000_000f));
		directed_plan.push_back(request_row(OP_FREE, 1'b1, 32'hffff_ffff));
		directed_plan.push_back(request_row(OP_ALLOC, 1'b0, 32'h0));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < directed_plan.size(); row++) begin
			if (directed_plan[row].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed_plan[row].reg_idx, directed_plan[row].value);
			end else begin
				issue_request(directed_plan[row].op, directed_plan[row].clr,
					directed_plan[row].value, directed_plan[row].typed, directed_plan[row].want);
			end
		end

		// Random phases, each with a fresh pool geometry. Most requests are
		// allocates and frees of blocks actually held, so the list is pushed
		// and popped deep; the rest are frees of random, misaligned, out of
		// range or already free addresses.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			write_reg(REG_BASE, pick_base());
			write_reg(REG_SIZE, pick_size());
			write_reg(REG_COUNT, pick_count());
			burst_mode = (phase == PRESSURE_PHASE) || ($urandom_range(0, 2) == 0);
			if (phase == PRESSURE_PHASE) hold_rsp = 1'b1;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = $urandom_range(0, 99);
				clr = 1'($urandom_range(0, 1));
				addr = $urandom();
				op = OP_FREE;
				if (r < 45) begin
					op = OP_ALLOC;
				end else if (r < 85 && granted_blocks.size() != 0) begin
					k = $urandom_range(0, granted_blocks.size() - 1);
					addr = granted_blocks[k];
					granted_blocks.delete(k);
				end else begin
					case ($urandom_range(0, 3))
						0: ;
						1: addr = ADDR_W'(64'(pool_base)
							+ 64'($urandom_range(0, pool_blocks)) * 64'(pool_stride));
						2: addr = ADDR_W'(64'(pool_base)
							+ 64'($urandom_range(0, pool_blocks)) * 64'(pool_stride)
							+ 64'($urandom_range(1, pool_stride - 1)));
						default: addr = pool_base - ADDR_W'($urandom_range(1, 64));
					endcase
				end
				issue_request(op, clr, addr, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("fixed_block_pool_allocator verification clean");
		end else begin
			$display("fixed_block_pool_allocator verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_front.sv
rtl/fbpa_queue.sv
rtl/fbpa_back.sv
rtl/fixed_block_pool_allocator.sv
tb/sv/tb.sv
